[hw/rtl/rti_pkg.sv]
`timescale 1ns / 1ps

package rti_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF   = 8;

    localparam int                   THR_WIDTH = 32;
    localparam logic [THR_WIDTH-1:0] THR_RESET = 32'd1678;

    localparam int APB_ADDR_WIDTH = 5;
    localparam int APB_DATA_WIDTH = 32;

    typedef enum logic [2:0] {
        REG_ORG_X     = 3'd0,
        REG_ORG_Y     = 3'd1,
        REG_ORG_Z     = 3'd2,
        REG_DIR_X     = 3'd3,
        REG_DIR_Y     = 3'd4,
        REG_DIR_Z     = 3'd5,
        REG_THRESHOLD = 3'd6
    } reg_idx_t;

    // Per-lane control that travels beside the divider data.
    typedef struct packed {
        logic valid;
        logic hit;
        logic neg;
    } lane_ctl_t;

endpackage

[hw/rtl/rti_mul.sv]
`timescale 1ns / 1ps

// Two-stage signed multiplier. The b operand is cut into chunks so that each
// partial product is A_WIDTH + CHUNK_WIDTH + 1 bits wide; the partial
// products are registered and summed in the second stage.
module rti_mul #(
    parameter int A_WIDTH     = 25,
    parameter int B_WIDTH     = 50,
    parameter int CHUNK_WIDTH = 26
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [A_WIDTH-1:0]         a,
    input  logic signed [B_WIDTH-1:0]         b,
    output logic signed [A_WIDTH+B_WIDTH-1:0] p
);

    localparam int NCHUNK    = (B_WIDTH + CHUNK_WIDTH - 1) / CHUNK_WIDTH;
    localparam int TOP_WIDTH = B_WIDTH - (NCHUNK - 1) * CHUNK_WIDTH;
    localparam int PP_WIDTH  = A_WIDTH + CHUNK_WIDTH + 1;
    localparam int P_WIDTH   = A_WIDTH + B_WIDTH;

    logic signed [PP_WIDTH-1:0] pp_reg [NCHUNK];
    logic signed [P_WIDTH-1:0]  sum_next;
    logic signed [P_WIDTH-1:0]  p_reg;

    for (genvar k = 0; k < NCHUNK; k++) begin : g_pp
        logic signed [CHUNK_WIDTH:0] chunk;
        if (k < NCHUNK - 1) begin : g_low
            assign chunk = signed'({1'b0, b[k*CHUNK_WIDTH +: CHUNK_WIDTH]});
        end else begin : g_top
            assign chunk = (CHUNK_WIDTH+1)'(signed'(b[B_WIDTH-1 -: TOP_WIDTH]));
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                pp_reg[k] <= PP_WIDTH'(a) * PP_WIDTH'(chunk);
            end
        end
    end

    always_comb begin
        sum_next = '0;
        for (int k = 0; k < NCHUNK; k++) begin
            sum_next = sum_next + (P_WIDTH'(pp_reg[k]) <<< (k * CHUNK_WIDTH));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= sum_next;
        end
    end

    assign p = p_reg;

endmodule

[hw/rtl/rti_geom.sv]
`timescale 1ns / 1ps

// Geometry pipeline: edges, cross and dot products, determinant sign fix,
// the hit tests and the pick numerators. Twelve register stages.
module rti_geom import rti_pkg::*; #(
    parameter  int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int DET_WIDTH   = 3 * COORD_WIDTH + 5,
    localparam int NUM_WIDTH   = 4 * COORD_WIDTH + 7
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] v0 [3],
    input  logic signed [COORD_WIDTH-1:0] v1 [3],
    input  logic signed [COORD_WIDTH-1:0] v2 [3],
    input  logic signed [COORD_WIDTH-1:0] org [3],
    input  logic signed [COORD_WIDTH-1:0] dir [3],
    input  logic [THR_WIDTH-1:0]          thr,
    output lane_ctl_t                     ctl_out [3],
    output logic [NUM_WIDTH-1:0]          num_mag [3],
    output logic [DET_WIDTH-1:0]          det_out,
    output logic signed [COORD_WIDTH-1:0] base [3]
);

    localparam int E_W     = COORD_WIDTH + 1;
    localparam int X1_W    = COORD_WIDTH + E_W;
    localparam int X2_W    = 2 * E_W;
    localparam int P_W     = X1_W + 1;
    localparam int Q_W     = X2_W + 1;
    localparam int M1_W    = E_W + P_W;
    localparam int M2_W    = COORD_WIDTH + Q_W;
    localparam int M3_W    = E_W + DET_WIDTH;
    localparam int CHUNK_W = COORD_WIDTH + 2;
    localparam int NSTG    = 12;

    logic [NSTG-1:0] vld_reg;

    logic signed [COORD_WIDTH-1:0] v0_reg [NSTG][3];
    logic signed [E_W-1:0]         e1_reg [8][3];
    logic signed [E_W-1:0]         e2_reg [8][3];
    logic signed [E_W-1:0]         tp_reg [3][3];

    logic signed [X1_W-1:0] pa_reg [3];
    logic signed [X1_W-1:0] pb_reg [3];
    logic signed [X2_W-1:0] qa_reg [3];
    logic signed [X2_W-1:0] qb_reg [3];
    logic signed [P_W-1:0]  pvec_reg [3];
    logic signed [Q_W-1:0]  qvec_reg [3];

    logic signed [M1_W-1:0] dm [3];
    logic signed [M1_W-1:0] um [3];
    logic signed [M2_W-1:0] vm [3];

    logic signed [DET_WIDTH-1:0] det5_reg, u5_reg, v5_reg;
    logic signed [DET_WIDTH-1:0] det6_reg, u6_reg, v6_reg;
    logic signed [DET_WIDTH-1:0] u7_reg, v7_reg;
    logic [DET_WIDTH-1:0]        det_reg [7:11];
    logic [11:7]                 hit_reg;
    logic                        det5_pos;
    logic                        below_thr, u_gt, uv_gt, hit7_next;
    logic signed [DET_WIDTH:0]   uv_sum;

    logic signed [M3_W-1:0]      nu [3];
    logic signed [M3_W-1:0]      nv [3];
    logic signed [NUM_WIDTH-1:0] num10_reg [3];
    logic [NUM_WIDTH-1:0]        mag11_reg [3];
    logic [2:0]                  neg11_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    // Stage 0: edges and the origin offset.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                v0_reg[0][i] <= v0[i];
                e1_reg[0][i] <= E_W'(v1[i]) - E_W'(v0[i]);
                e2_reg[0][i] <= E_W'(v2[i]) - E_W'(v0[i]);
                tp_reg[0][i] <= E_W'(org[i]) - E_W'(v0[i]);
            end
            for (int s = 1; s < NSTG; s++) begin
                v0_reg[s] <= v0_reg[s-1];
            end
            for (int s = 1; s < 8; s++) begin
                e1_reg[s] <= e1_reg[s-1];
                e2_reg[s] <= e2_reg[s-1];
            end
            for (int s = 1; s < 3; s++) begin
                tp_reg[s] <= tp_reg[s-1];
            end
        end
    end

    // Stages 1 and 2: cross products dir x e2 and tpos x e1.
    for (genvar i = 0; i < 3; i++) begin : g_cross
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;
        always_ff @(posedge aclk) begin
            if (en) begin
                pa_reg[i]   <= X1_W'(dir[J]) * X1_W'(e2_reg[0][K]);
                pb_reg[i]   <= X1_W'(dir[K]) * X1_W'(e2_reg[0][J]);
                qa_reg[i]   <= X2_W'(tp_reg[0][J]) * X2_W'(e1_reg[0][K]);
                qb_reg[i]   <= X2_W'(tp_reg[0][K]) * X2_W'(e1_reg[0][J]);
                pvec_reg[i] <= P_W'(pa_reg[i]) - P_W'(pb_reg[i]);
                qvec_reg[i] <= Q_W'(qa_reg[i]) - Q_W'(qb_reg[i]);
            end
        end

        // Stages 3 and 4: dot product terms.
        rti_mul #(.A_WIDTH(E_W), .B_WIDTH(P_W), .CHUNK_WIDTH(CHUNK_W)) u_det_mul (
            .aclk (aclk), .en (en), .a (e1_reg[2][i]), .b (pvec_reg[i]), .p (dm[i])
        );
        rti_mul #(.A_WIDTH(E_W), .B_WIDTH(P_W), .CHUNK_WIDTH(CHUNK_W)) u_u_mul (
            .aclk (aclk), .en (en), .a (tp_reg[2][i]), .b (pvec_reg[i]), .p (um[i])
        );
        rti_mul #(.A_WIDTH(COORD_WIDTH), .B_WIDTH(Q_W), .CHUNK_WIDTH(CHUNK_W)) u_v_mul (
            .aclk (aclk), .en (en), .a (dir[i]), .b (qvec_reg[i]), .p (vm[i])
        );

        // Stages 8 and 9: pick numerator terms.
        rti_mul #(.A_WIDTH(E_W), .B_WIDTH(DET_WIDTH), .CHUNK_WIDTH(CHUNK_W)) u_nu_mul (
            .aclk (aclk), .en (en), .a (e1_reg[7][i]), .b (u7_reg), .p (nu[i])
        );
        rti_mul #(.A_WIDTH(E_W), .B_WIDTH(DET_WIDTH), .CHUNK_WIDTH(CHUNK_W)) u_nv_mul (
            .aclk (aclk), .en (en), .a (e2_reg[7][i]), .b (v7_reg), .p (nv[i])
        );

        // Stages 10 and 11: numerator sum, then sign and magnitude.
        always_ff @(posedge aclk) begin
            if (en) begin
                num10_reg[i] <= NUM_WIDTH'(nu[i]) + NUM_WIDTH'(nv[i]);
                neg11_reg[i] <= num10_reg[i][NUM_WIDTH-1];
                mag11_reg[i] <= num10_reg[i][NUM_WIDTH-1] ? NUM_WIDTH'(-num10_reg[i])
                                                          : NUM_WIDTH'(num10_reg[i]);
            end
        end

        assign ctl_out[i] = '{valid: vld_reg[NSTG-1], hit: hit_reg[11], neg: neg11_reg[i]};
        assign num_mag[i] = mag11_reg[i];
        assign base[i]    = v0_reg[NSTG-1][i];
    end

    // Stage 5: sums of the dot product terms.
    always_ff @(posedge aclk) begin
        if (en) begin
            det5_reg <= DET_WIDTH'(dm[0]) + DET_WIDTH'(dm[1]) + DET_WIDTH'(dm[2]);
            u5_reg   <= DET_WIDTH'(um[0]) + DET_WIDTH'(um[1]) + DET_WIDTH'(um[2]);
            v5_reg   <= DET_WIDTH'(vm[0]) + DET_WIDTH'(vm[1]) + DET_WIDTH'(vm[2]);
        end
    end

    // Stage 6: a non-positive determinant flips tvec, so u and v flip as well.
    assign det5_pos = !det5_reg[DET_WIDTH-1] && (det5_reg != '0);

    always_ff @(posedge aclk) begin
        if (en) begin
            det6_reg <= det5_pos ? det5_reg : -det5_reg;
            u6_reg   <= det5_pos ? u5_reg : -u5_reg;
            v6_reg   <= det5_pos ? v5_reg : -v5_reg;
        end
    end

    // Stage 7: rejection tests.
    always_comb begin
        uv_sum    = (DET_WIDTH+1)'(u6_reg) + (DET_WIDTH+1)'(v6_reg);
        below_thr = $unsigned(det6_reg) < DET_WIDTH'(thr);
        u_gt      = u6_reg > det6_reg;
        uv_gt     = uv_sum > (DET_WIDTH+1)'(det6_reg);
        hit7_next = (det6_reg != '0) && !below_thr && !u6_reg[DET_WIDTH-1] && !u_gt
                    && !v6_reg[DET_WIDTH-1] && !uv_gt;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u7_reg     <= u6_reg;
            v7_reg     <= v6_reg;
            det_reg[7] <= $unsigned(det6_reg);
            hit_reg[7] <= hit7_next;
            for (int s = 8; s <= 11; s++) begin
                det_reg[s] <= det_reg[s-1];
                hit_reg[s] <= hit_reg[s-1];
            end
        end
    end

    assign det_out = det_reg[11];

endmodule

[hw/rtl/rti_div.sv]
`timescale 1ns / 1ps

// One pick lane: restoring divider with one quotient bit per stage, then
// round to nearest (ties away from zero), add to the vertex and saturate.
module rti_div import rti_pkg::*; #(
    parameter  int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int DET_WIDTH   = 3 * COORD_WIDTH + 5,
    localparam int NUM_WIDTH   = 4 * COORD_WIDTH + 7
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  lane_ctl_t                     ctl_in,
    input  logic [NUM_WIDTH-1:0]          num_mag,
    input  logic [DET_WIDTH-1:0]          det,
    input  logic signed [COORD_WIDTH-1:0] base_in,
    output lane_ctl_t                     ctl_out,
    output logic signed [COORD_WIDTH-1:0] pick
);

    localparam int QW = COORD_WIDTH + 1;
    localparam int SW = COORD_WIDTH + 3;
    localparam logic signed [SW-1:0] S_MAX = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] S_MIN = ~S_MAX;

    logic [NUM_WIDTH-1:0]          rem_reg  [QW];
    logic [QW-1:0]                 quo_reg  [QW];
    logic [DET_WIDTH-1:0]          det_reg  [QW];
    logic signed [COORD_WIDTH-1:0] base_reg [QW];
    lane_ctl_t                     ctl_reg  [QW];

    logic [QW:0]                   qr_reg;
    logic signed [COORD_WIDTH-1:0] base_r_reg;
    lane_ctl_t                     ctl_r_reg;
    logic                          round_up;
    logic signed [SW-1:0]          qs, sum;
    logic signed [COORD_WIDTH-1:0] sat;
    logic signed [COORD_WIDTH-1:0] pick_reg;
    lane_ctl_t                     ctl_o_reg;

    for (genvar k = 0; k < QW; k++) begin : g_step
        localparam int SH = QW - 1 - k;
        logic [NUM_WIDTH-1:0]          rem_in;
        logic [QW-1:0]                 quo_in;
        logic [DET_WIDTH-1:0]          det_in;
        logic signed [COORD_WIDTH-1:0] b_in;
        lane_ctl_t                     c_in;
        logic [NUM_WIDTH-1:0]          dsh;
        logic                          ge;

        if (k == 0) begin : g_first
            assign rem_in = num_mag;
            assign quo_in = '0;
            assign det_in = det;
            assign b_in   = base_in;
            assign c_in   = ctl_in;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign det_in = det_reg[k-1];
            assign b_in   = base_reg[k-1];
            assign c_in   = ctl_reg[k-1];
        end

        assign dsh = NUM_WIDTH'(det_in) << SH;
        assign ge  = rem_in >= dsh;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[k] <= '0;
            end else if (en) begin
                ctl_reg[k] <= c_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? rem_in - dsh : rem_in;
                quo_reg[k]  <= quo_in | (QW'(ge) << SH);
                det_reg[k]  <= det_in;
                base_reg[k] <= b_in;
            end
        end
    end

    assign round_up = {1'b0, rem_reg[QW-1], 1'b0} >= (NUM_WIDTH+2)'(det_reg[QW-1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_r_reg <= '0;
            ctl_o_reg <= '0;
        end else if (en) begin
            ctl_r_reg <= ctl_reg[QW-1];
            ctl_o_reg <= ctl_r_reg;
        end
    end

    always_comb begin
        qs  = signed'({1'b0, qr_reg});
        sum = ctl_r_reg.neg ? SW'(base_r_reg) - qs : SW'(base_r_reg) + qs;
        if (sum > S_MAX) begin
            sat = S_MAX[COORD_WIDTH-1:0];
        end else if (sum < S_MIN) begin
            sat = S_MIN[COORD_WIDTH-1:0];
        end else begin
            sat = sum[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qr_reg     <= (QW+1)'(quo_reg[QW-1]) + (QW+1)'(round_up);
            base_r_reg <= base_reg[QW-1];
            pick_reg   <= ctl_r_reg.hit ? sat : '0;
        end
    end

    assign ctl_out = ctl_o_reg;
    assign pick    = pick_reg;

endmodule

[hw/rtl/ray_triangle_intersect.sv]
`timescale 1ns / 1ps

// Two-sided Moller-Trumbore ray/triangle test. The ray (origin, direction,
// signed fixed point) and the parallel threshold sit in APB registers; one
// triangle (three vertices) arrives per input transaction and yields one
// result transaction: a hit flag and the hit point, saturated to the
// coordinate range and zero on a miss. The block is fully pipelined and
// takes a new triangle every cycle while the output is not stalled. A result
// passes through twelve stages of geometry (edges, cross products, split
// multipliers, the sign fix and the rejection tests, the pick numerators)
// and then through a divider that resolves one quotient bit per stage over
// COORD_WIDTH + 1 stages, followed by a rounding stage and a saturation
// stage. The whole pipeline advances whenever the output register is empty
// or its result is being taken, so that s_ready follows
// m_ready combinationally. Registers: ray origin x/y/z at 0x00/0x04/0x08,
// direction x/y/z at 0x0C/0x10/0x14 and the threshold at 0x18, in units of
// the determinant (2^-(3*FRAC_BITS)). Write them only while no transaction
// is in flight.
module ray_triangle_intersect import rti_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_WIDTH-1:0]     paddr,
    input  logic [APB_DATA_WIDTH-1:0]     pwdata,
    output logic [APB_DATA_WIDTH-1:0]     prdata,
    output logic                          pready,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_v0_x,
    input  logic signed [COORD_WIDTH-1:0] s_v0_y,
    input  logic signed [COORD_WIDTH-1:0] s_v0_z,
    input  logic signed [COORD_WIDTH-1:0] s_v1_x,
    input  logic signed [COORD_WIDTH-1:0] s_v1_y,
    input  logic signed [COORD_WIDTH-1:0] s_v1_z,
    input  logic signed [COORD_WIDTH-1:0] s_v2_x,
    input  logic signed [COORD_WIDTH-1:0] s_v2_y,
    input  logic signed [COORD_WIDTH-1:0] s_v2_z,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic signed [COORD_WIDTH-1:0] m_pick_x,
    output logic signed [COORD_WIDTH-1:0] m_pick_y,
    output logic signed [COORD_WIDTH-1:0] m_pick_z
);

    localparam int DET_WIDTH = 3 * COORD_WIDTH + 5;
    localparam int NUM_WIDTH = 4 * COORD_WIDTH + 7;
    localparam logic signed [COORD_WIDTH-1:0] DIR_Z_RESET = COORD_WIDTH'(1) << FRAC_BITS;

    // Configuration registers.
    logic signed [COORD_WIDTH-1:0] org_reg [3];
    logic signed [COORD_WIDTH-1:0] dir_reg [3];
    logic [THR_WIDTH-1:0]          thr_reg;
    logic                          cfg_wr;
    reg_idx_t                      cfg_idx;

    // Pipeline wiring.
    logic                          en;
    logic signed [COORD_WIDTH-1:0] v0_in [3];
    logic signed [COORD_WIDTH-1:0] v1_in [3];
    logic signed [COORD_WIDTH-1:0] v2_in [3];
    lane_ctl_t                     lane_ctl [3];
    logic [NUM_WIDTH-1:0]          num_mag [3];
    logic [DET_WIDTH-1:0]          det;
    logic signed [COORD_WIDTH-1:0] base [3];
    lane_ctl_t                     out_ctl;
    logic signed [COORD_WIDTH-1:0] pick [3];

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= DIR_Z_RESET;
            thr_reg    <= THR_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ORG_X:     org_reg[0] <= pwdata[COORD_WIDTH-1:0];
                REG_ORG_Y:     org_reg[1] <= pwdata[COORD_WIDTH-1:0];
                REG_ORG_Z:     org_reg[2] <= pwdata[COORD_WIDTH-1:0];
                REG_DIR_X:     dir_reg[0] <= pwdata[COORD_WIDTH-1:0];
                REG_DIR_Y:     dir_reg[1] <= pwdata[COORD_WIDTH-1:0];
                REG_DIR_Z:     dir_reg[2] <= pwdata[COORD_WIDTH-1:0];
                REG_THRESHOLD: thr_reg    <= pwdata[THR_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Reads return the raw register bits, zero-extended.
    always_comb begin
        case (cfg_idx)
            REG_ORG_X:     prdata = APB_DATA_WIDTH'($unsigned(org_reg[0]));
            REG_ORG_Y:     prdata = APB_DATA_WIDTH'($unsigned(org_reg[1]));
            REG_ORG_Z:     prdata = APB_DATA_WIDTH'($unsigned(org_reg[2]));
            REG_DIR_X:     prdata = APB_DATA_WIDTH'($unsigned(dir_reg[0]));
            REG_DIR_Y:     prdata = APB_DATA_WIDTH'($unsigned(dir_reg[1]));
            REG_DIR_Z:     prdata = APB_DATA_WIDTH'($unsigned(dir_reg[2]));
            REG_THRESHOLD: prdata = APB_DATA_WIDTH'(thr_reg);
            default:       prdata = '0;
        endcase
    end

    // The pipeline moves as a whole whenever the output register can take a
    // new result; a stall freezes every stage, so nothing is lost or repeated.
    assign en      = !out_ctl.valid || m_ready;
    assign s_ready = en;

    assign v0_in[0] = s_v0_x;
    assign v0_in[1] = s_v0_y;
    assign v0_in[2] = s_v0_z;
    assign v1_in[0] = s_v1_x;
    assign v1_in[1] = s_v1_y;
    assign v1_in[2] = s_v1_z;
    assign v2_in[0] = s_v2_x;
    assign v2_in[1] = s_v2_y;
    assign v2_in[2] = s_v2_z;

    rti_geom #(.COORD_WIDTH(COORD_WIDTH)) u_geom (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .v0       (v0_in),
        .v1       (v1_in),
        .v2       (v2_in),
        .org      (org_reg),
        .dir      (dir_reg),
        .thr      (thr_reg),
        .ctl_out  (lane_ctl),
        .num_mag  (num_mag),
        .det_out  (det),
        .base     (base)
    );

    // Lane 0 also carries the valid and hit flags for the result transaction;
    // the other lanes carry identical copies that are not needed here.
    rti_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_in  (lane_ctl[0]),
        .num_mag (num_mag[0]),
        .det     (det),
        .base_in (base[0]),
        .ctl_out (out_ctl),
        .pick    (pick[0])
    );

    rti_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_in  (lane_ctl[1]),
        .num_mag (num_mag[1]),
        .det     (det),
        .base_in (base[1]),
        .ctl_out (),
        .pick    (pick[1])
    );

    rti_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_z (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_in  (lane_ctl[2]),
        .num_mag (num_mag[2]),
        .det     (det),
        .base_in (base[2]),
        .ctl_out (),
        .pick    (pick[2])
    );

    assign m_valid  = out_ctl.valid;
    assign m_hit    = out_ctl.hit;
    assign m_pick_x = pick[0];
    assign m_pick_y = pick[1];
    assign m_pick_z = pick[2];

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

// Self-checking bench for the ray/triangle intersection block.
// Triangles go in over a valid/ready channel, one hit result comes back for
// each, and every result transaction is checked against a miss typed into the
// table or a wide-integer model of the two-sided Moller-Trumbore test in this module.
module tb_top;
    import rti_pkg::*;

    localparam int CW         = COORD_WIDTH_DEF;
    localparam int LATENCY    = CW + 15;
    localparam int WATCHDOG   = 5000;
    localparam int LONG_HOLD  = 400;
    localparam int PHASE_ITEMS = 250;

    // All intermediate products fit comfortably in 160 bits.
    typedef logic signed [159:0] wide_t;
    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        coord_t vtx [9];
    } triangle_t;

    typedef struct {
        logic   hit;
        coord_t pick [3];
    } hit_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_ADDR_WIDTH-1:0] paddr = '0;
    logic [APB_DATA_WIDTH-1:0] pwdata = '0;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;

    logic   s_valid = 1'b0;
    logic   s_ready;
    coord_t s_v0_x = '0, s_v0_y = '0, s_v0_z = '0;
    coord_t s_v1_x = '0, s_v1_y = '0, s_v1_z = '0;
    coord_t s_v2_x = '0, s_v2_y = '0, s_v2_z = '0;

    logic   m_valid;
    logic   m_ready = 1'b0;
    logic   m_hit;
    coord_t m_pick_x, m_pick_y, m_pick_z;

    always #5 aclk = ~aclk;

    ray_triangle_intersect dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_v0_x   (s_v0_x),
        .s_v0_y   (s_v0_y),
        .s_v0_z   (s_v0_z),
        .s_v1_x   (s_v1_x),
        .s_v1_y   (s_v1_y),
        .s_v1_z   (s_v1_z),
        .s_v2_x   (s_v2_x),
        .s_v2_y   (s_v2_y),
        .s_v2_z   (s_v2_z),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_hit    (m_hit),
        .m_pick_x (m_pick_x),
        .m_pick_y (m_pick_y),
        .m_pick_z (m_pick_z)
    );

    // Shadow copy of the ray registers, updated on every APB write.
    coord_t      ray_org [3];
    coord_t      ray_dir [3];
    logic [31:0] par_thr;

    hit_result_t pending_hits [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    logic        long_hold = 1'b0;
    logic        start_hold = 1'b0;
    int          result_count = 0;

    // Sign-extend a coordinate into the wide arithmetic domain.
    function automatic wide_t widen(coord_t c);
        wide_t w;
        w = c;
        return w;
    endfunction

    // Rounded, saturated pick component: base + num / det, det positive.
    function automatic coord_t pick_component(coord_t base, wide_t num, wide_t det);
        logic   neg;
        wide_t  mag, quo, rem;
        longint qi, sum;
        neg = num < 0;
        mag = neg ? -num : num;
        quo = mag / det;
        rem = mag % det;
        if ((rem <<< 1) >= det) quo = quo + 1;
        if (quo[159:40] != 0) qi = longint'(1) <<< 40;
        else qi = longint'(quo[39:0]);
        sum = neg ? longint'(base) - qi : longint'(base) + qi;
        if (sum < -(longint'(1) <<< (CW - 1))) sum = -(longint'(1) <<< (CW - 1));
        if (sum > (longint'(1) <<< (CW - 1)) - 1) sum = (longint'(1) <<< (CW - 1)) - 1;
        return coord_t'(sum);
    endfunction

    // Full intersection test of one triangle against the shadowed ray.
    function automatic hit_result_t intersect_ray(triangle_t trg);
        hit_result_t res;
        wide_t org [3], dir [3], v0 [3], e1 [3], e2 [3];
        wide_t pv [3], tv [3], qv [3];
        wide_t det, u, v, thr;
        logic  pos;
        res.hit = 1'b0;
        for (int i = 0; i < 3; i++) res.pick[i] = '0;
        for (int i = 0; i < 3; i++) begin
            org[i] = widen(ray_org[i]);
            dir[i] = widen(ray_dir[i]);
            v0[i]  = widen(trg.vtx[i]);
            e1[i]  = widen(trg.vtx[3 + i]) - v0[i];
            e2[i]  = widen(trg.vtx[6 + i]) - v0[i];
        end
        pv[0] = dir[1] * e2[2] - dir[2] * e2[1];
        pv[1] = dir[2] * e2[0] - dir[0] * e2[2];
        pv[2] = dir[0] * e2[1] - dir[1] * e2[0];
        det = e1[0] * pv[0] + e1[1] * pv[1] + e1[2] * pv[2];
        pos = det > 0;
        for (int i = 0; i < 3; i++) tv[i] = pos ? org[i] - v0[i] : v0[i] - org[i];
        if (!pos) det = -det;
        thr = '0;
        thr[31:0] = par_thr;
        if (det == 0 || det < thr) return res;
        u = tv[0] * pv[0] + tv[1] * pv[1] + tv[2] * pv[2];
        if (u < 0 || u > det) return res;
        qv[0] = tv[1] * e1[2] - tv[2] * e1[1];
        qv[1] = tv[2] * e1[0] - tv[0] * e1[2];
        qv[2] = tv[0] * e1[1] - tv[1] * e1[0];
        v = dir[0] * qv[0] + dir[1] * qv[1] + dir[2] * qv[2];
        if (v < 0 || u + v > det) return res;
        res.hit = 1'b1;
        for (int i = 0; i < 3; i++)
            res.pick[i] = pick_component(trg.vtx[i], e1[i] * u + e2[i] * v, det);
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH result %0d %s: got %0d, expected %0d",
                 result_count, what, got, want);
        error_count++;
    endtask

    // Result checker: every accepted result is compared with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_hits.size() == 0) begin
                report_mismatch("unexpected transaction", 1, 0);
            end else begin
                hit_result_t want;
                want = pending_hits.pop_front();
                if (m_hit !== want.hit) report_mismatch("hit", m_hit, want.hit);
                if (m_pick_x !== want.pick[0]) report_mismatch("pick_x", m_pick_x, want.pick[0]);
                if (m_pick_y !== want.pick[1]) report_mismatch("pick_y", m_pick_y, want.pick[1]);
                if (m_pick_z !== want.pick[2]) report_mismatch("pick_z", m_pick_z, want.pick[2]);
            end
            result_count++;
        end
    end

    // Receiver: stall pattern, none to heavy, redrawn when mode_count wraps.
    int stall_mode = 0;
    int mode_count = 0;
    always @(posedge aclk) begin
        if (mode_count == 63) begin
            stall_mode <= $urandom_range(0, 3);
        end
        mode_count <= (mode_count + 1) % 64;
        case (stall_mode)
            0: m_ready <= !long_hold;
            1: m_ready <= !long_hold && ($urandom_range(0, 3) != 0);
            2: m_ready <= !long_hold && $urandom_range(0, 1);
            default: m_ready <= !long_hold && ($urandom_range(0, 7) == 0);
        endcase
    end

    // A long hold-off on the result side, so the pipeline fills up and
    // back-pressures the input channel while the sender keeps offering.
    initial begin
        wait (start_hold);
        @(posedge aclk);
        long_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge aclk);
        long_hold <= 1'b0;
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // APB write: a setup phase, then an access phase; pready is always high.
    // The bus is left selected so that the next write can start its setup
    // phase right away; write_ray releases it after the last write.
    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_WIDTH'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx == REG_THRESHOLD) par_thr = value;
        else if (idx >= REG_DIR_X) ray_dir[idx - REG_DIR_X] = value[CW-1:0];
        else ray_org[idx] = value[CW-1:0];
    endtask

    // Upper bits of coordinate writes are random; the block ignores them.
    task automatic write_ray(coord_t org [3], coord_t dir [3], logic [31:0] thr);
        write_reg(REG_ORG_X, {8'($urandom_range(0, 255)), org[0]});
        write_reg(REG_ORG_Y, {8'($urandom_range(0, 255)), org[1]});
        write_reg(REG_ORG_Z, {8'($urandom_range(0, 255)), org[2]});
        write_reg(REG_DIR_X, {8'($urandom_range(0, 255)), dir[0]});
        write_reg(REG_DIR_Y, {8'($urandom_range(0, 255)), dir[1]});
        write_reg(REG_DIR_Z, {8'($urandom_range(0, 255)), dir[2]});
        write_reg(REG_THRESHOLD, thr);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one triangle and wait for its acceptance. Valid stays high
    // afterwards, so back-to-back transactions need no extra edge.
    task automatic send_triangle(triangle_t trg, logic typed, hit_result_t typed_res);
        s_valid <= 1'b1;
        s_v0_x <= trg.vtx[0]; s_v0_y <= trg.vtx[1]; s_v0_z <= trg.vtx[2];
        s_v1_x <= trg.vtx[3]; s_v1_y <= trg.vtx[4]; s_v1_z <= trg.vtx[5];
        s_v2_x <= trg.vtx[6]; s_v2_y <= trg.vtx[7]; s_v2_z <= trg.vtx[8];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_hits.push_back(typed ? typed_res : intersect_ray(trg));
    endtask

    // Idle gap between bursts on the input side.
    int burst_left = 0;
    task automatic sender_pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 1) ? $urandom_range(20, 80) : $urandom_range(1, 8);
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    endtask

    function automatic coord_t clamp_coord(longint x);
        if (x > (longint'(1) <<< (CW - 1)) - 1) return coord_t'((longint'(1) <<< (CW - 1)) - 1);
        if (x < -(longint'(1) <<< (CW - 1))) return coord_t'(-(longint'(1) <<< (CW - 1)));
        return coord_t'(x);
    endfunction

    // Mostly triangles placed around a point on the ray, so that many of
    // them are hit; the rest have fully random vertices.
    function automatic triangle_t random_triangle();
        triangle_t trg;
        longint    center, spread, step;
        if ($urandom_range(0, 9) < 3) begin
            for (int i = 0; i < 9; i++) trg.vtx[i] = coord_t'($urandom);
        end else begin
            step   = $urandom_range(0, 6);
            spread = longint'(1) <<< $urandom_range(2, 20);
            for (int i = 0; i < 3; i++) begin
                center = longint'(ray_org[i]) + ((longint'(ray_dir[i]) * step) >>> 1);
                for (int j = 0; j < 3; j++)
                    trg.vtx[3 * j + i] = clamp_coord(center
                        + longint'($urandom_range(0, 2 * spread)) - spread);
            end
        end
        return trg;
    endfunction

    function automatic triangle_t make_triangle(int a0, int a1, int a2, int b0, int b1,
                                                int b2, int c0, int c1, int c2);
        triangle_t trg;
        trg.vtx[0] = coord_t'(a0); trg.vtx[1] = coord_t'(a1); trg.vtx[2] = coord_t'(a2);
        trg.vtx[3] = coord_t'(b0); trg.vtx[4] = coord_t'(b1); trg.vtx[5] = coord_t'(b2);
        trg.vtx[6] = coord_t'(c0); trg.vtx[7] = coord_t'(c1); trg.vtx[8] = coord_t'(c2);
        return trg;
    endfunction

    // Directed stimulus table. Rows flagged as typed carry a result that is
    // plain to see (all of them misses); the others go through the model.
    localparam int DIRECTED_ROWS = 14;
    triangle_t   directed_tri   [DIRECTED_ROWS];
    logic        directed_typed [DIRECTED_ROWS];
    hit_result_t miss_result;

    initial begin
        coord_t org [3];
        coord_t dir [3];

        miss_result.hit = 1'b0;
        for (int i = 0; i < 3; i++) miss_result.pick[i] = '0;

        // Degenerate triangle at the origin: zero determinant, a miss.
        directed_tri[0]  = make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0);
        // All vertices at the positive and the negative extreme.
        directed_tri[1]  = make_triangle(8388607, 8388607, 8388607, 8388607, 8388607,
                                         8388607, 8388607, 8388607, 8388607);
        directed_tri[2]  = make_triangle(-8388608, -8388608, -8388608, -8388608, -8388608,
                                         -8388608, -8388608, -8388608, -8388608);
        // Triangle in a plane parallel to the ray: zero determinant.
        directed_tri[3]  = make_triangle(0, 0, 0, 256, 0, 0, 0, 0, 256);
        // Tiny triangle whose determinant is below the reset threshold.
        directed_tri[4]  = make_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0);
        // Facing triangle straddling the ray, and the same one wound the
        // other way round, so the determinant flips sign.
        directed_tri[5]  = make_triangle(-256, -256, 2560, 256, -256, 2560, -256, 256, 2560);
        directed_tri[6]  = make_triangle(-256, -256, 2560, -256, 256, 2560, 256, -256, 2560);
        // Ray passes outside the triangle: u below zero, u above det,
        // v below zero, u and v both below zero.
        directed_tri[7]  = make_triangle(256, 0, 512, 512, 0, 512, 256, 256, 512);
        directed_tri[8]  = make_triangle(-512, 0, 512, -256, 0, 512, -512, 256, 512);
        directed_tri[9]  = make_triangle(0, 256, 512, 256, 256, 512, 0, 512, 512);
        directed_tri[10] = make_triangle(128, 128, 512, 256, 128, 512, 128, 256, 512);
        // Triangle behind the origin and one across the whole coordinate range.
        directed_tri[11] = make_triangle(-256, -256, -2560, 256, -256, -2560, -256, 256, -2560);
        directed_tri[12] = make_triangle(-8388608, -8388608, 100, 8388607, -8388608, 100,
                                         -8388608, 8388607, 100);
        // Hit exactly on a vertex.
        directed_tri[13] = make_triangle(0, 0, 256, 256, 0, 256, 0, 256, 256);
        for (int i = 0; i < DIRECTED_ROWS; i++) directed_typed[i] = (i <= 4);

        ray_org = '{default: '0};
        ray_dir[0] = '0; ray_dir[1] = '0; ray_dir[2] = coord_t'(256);
        par_thr = THR_RESET;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows run against the reset ray.
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_triangle(directed_tri[i], directed_typed[i], miss_result);

        for (int phase = 0; phase < 6; phase++) begin
            s_valid <= 1'b0;
            wait (pending_hits.size() == 0);
            repeat (LATENCY) @(posedge aclk);
            case (phase)
                0: begin
                    org = '{default: '0};
                    dir[0] = 0; dir[1] = 0; dir[2] = 256;
                    write_ray(org, dir, 32'd0);
                end
                1: begin
                    org[0] = 8388607; org[1] = -8388608; org[2] = 8388607;
                    dir[0] = -8388608; dir[1] = 8388607; dir[2] = -8388608;
                    write_ray(org, dir, 32'hFFFF_FFFF);
                end
                2: begin
                    org[0] = -8388608; org[1] = 8388607; org[2] = -8388608;
                    dir[0] = 8388607; dir[1] = -8388608; dir[2] = 8388607;
                    write_ray(org, dir, 32'd1);
                end
                default: begin
                    for (int i = 0; i < 3; i++) begin
                        org[i] = coord_t'($urandom_range(0, 65535) - 32768);
                        dir[i] = coord_t'($urandom_range(0, 4095) - 2048);
                    end
                    write_ray(org, dir, $urandom_range(0, 1) ? $urandom_range(0, 5000)
                                                              : $urandom);
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 3 && n == 20) start_hold = 1'b1;
                sender_pace();
                send_triangle(random_triangle(), 1'b0, miss_result);
            end
        end
        s_valid <= 1'b0;

        wait (pending_hits.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/rti_pkg.sv
hw/rtl/rti_mul.sv
hw/rtl/rti_geom.sv
hw/rtl/rti_div.sv
hw/rtl/ray_triangle_intersect.sv
bench/tb_top.sv
